// ----- design/rhht_pkg.sv -----
// Package for the Robin Hood hash table: sizes, status codes and slot tag layout.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none
package rhht_pkg;
    localparam int TABLE_DEPTH = 1024;
    localparam int MAX_PROBE   = 64;
    localparam int KEY_BITS    = 32;
    localparam int HASH_BITS   = 58;
    localparam int DIST_BITS   = 6;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int PROBE_BITS  = $clog2(MAX_PROBE + 1);

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_PRESENT   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // load request registers, read the home slot
        logic clear_wr;  // write an empty tag at the clear index
        logic step;      // evaluate the slot read last, act, read next slot
        logic done_load; // never set by the controller; results load on the final step
    } rhht_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last; // clear index at final slot
        logic finished;   // the item ended on the step just taken
    } rhht_stat_t;
endpackage
`default_nettype wire

// ----- design/rhht_datapath.sv -----
// Datapath of the Robin Hood hash table: slot memories, carried entry, probe logic.
// Depends on rhht_pkg.
`default_nettype none
module rhht_datapath (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire rhht_pkg::rhht_cmd_t       cmd,
    output rhht_pkg::rhht_stat_t           stat,
    input  wire logic [3:0]                size_log2,
    input  wire logic                      in_opcode,
    input  wire logic [31:0]               in_key,
    input  wire logic [57:0]               in_hash,
    output logic [1:0]                     res_status,
    output logic [31:0]                    res_key,
    output logic                           res_ev_valid,
    output logic [31:0]                    res_ev_key,
    output logic [57:0]                    res_ev_hash
);
    import rhht_pkg::*;

    logic [63:0]         tag_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
    logic [63:0]         rd_tag_reg;
    logic [KEY_BITS-1:0] rd_key_reg;

    logic                 op_reg;
    logic [KEY_BITS-1:0]  req_key_reg, ck_reg;
    logic [HASH_BITS-1:0] ch_reg;
    logic [DIST_BITS-1:0] dist_reg;
    logic [PROBE_BITS-1:0] probe_reg;
    logic [IDX_BITS-1:0]  idx_reg, clr_reg;
    logic                 carry_new_reg;

    logic [IDX_BITS-1:0]  mask;
    logic [HASH_BITS-1:0] h_fix;
    logic [15:0]          mask_full;

    // Index mask saturates at the table depth.
    assign mask_full = (16'd1 << size_log2) - 16'd1;
    assign mask      = mask_full[IDX_BITS-1:0];
    assign h_fix     = (in_hash == '0) ? HASH_BITS'(64) : in_hash;

    // Evaluation of the slot read on the previous cycle.
    logic [DIST_BITS-1:0] rd_dist;
    logic                 empty, hash_eq, key_eq, last_probe;
    logic                 wr_en, fin;
    logic [1:0]           st;
    logic                 swap;
    assign rd_dist    = rd_tag_reg[63:58];
    assign empty      = (rd_tag_reg == '0);
    assign hash_eq    = (rd_tag_reg[57:0] == ch_reg);
    assign key_eq     = (rd_key_reg == req_key_reg);
    assign last_probe = (probe_reg == PROBE_BITS'(MAX_PROBE - 1));
    assign swap       = !empty && (rd_dist < dist_reg);

    always_comb begin
        wr_en = 1'b0;
        fin   = 1'b0;
        st    = ST_OVERFLOW;
        if (op_reg == OP_FIND) begin
            if (empty || (!hash_eq && (rd_dist < probe_reg[DIST_BITS-1:0]))) begin
                fin = 1'b1; st = ST_NOT_FOUND;
            end else if (hash_eq && key_eq) begin
                fin = 1'b1; st = ST_PRESENT;
            end else if (last_probe) begin
                fin = 1'b1; st = ST_NOT_FOUND;
            end
        end else begin
            if (empty) begin
                wr_en = 1'b1; fin = 1'b1; st = ST_INSERTED;
            end else if (swap) begin
                wr_en = 1'b1; fin = last_probe;
            end else if (carry_new_reg && key_eq) begin
                fin = 1'b1; st = ST_PRESENT;
            end else begin
                fin = last_probe;
            end
        end
    end

    assign stat.finished   = fin;
    assign stat.clear_last = (clr_reg == IDX_BITS'(TABLE_DEPTH - 1));

    logic [IDX_BITS-1:0] next_idx, rd_addr;
    assign next_idx = (idx_reg + IDX_BITS'(1)) & mask;
    assign rd_addr  = cmd.start ? (h_fix[IDX_BITS-1:0] & mask) : next_idx;

    // Slot memories: one write and one registered read per cycle.
    // A one-slot table reads back the entry written in the same cycle.
    always_ff @(posedge aclk) begin
        if (cmd.clear_wr) begin
            tag_mem[clr_reg] <= '0;
        end else if (cmd.step && wr_en) begin
            tag_mem[idx_reg] <= {dist_reg, ch_reg};
            key_mem[idx_reg] <= ck_reg;
        end
        if (cmd.step && wr_en && (rd_addr == idx_reg)) begin
            rd_tag_reg <= {dist_reg, ch_reg};
            rd_key_reg <= ck_reg;
        end else begin
            rd_tag_reg <= tag_mem[rd_addr];
            rd_key_reg <= key_mem[rd_addr];
        end
    end

    // Clear index walks every slot once after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_wr) begin
            clr_reg <= clr_reg + IDX_BITS'(1);
        end
    end

    // Request and carried entry registers.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg        <= in_opcode;
            req_key_reg   <= in_key;
            ck_reg        <= in_key;
            ch_reg        <= h_fix;
            dist_reg      <= '0;
            probe_reg     <= '0;
            carry_new_reg <= 1'b1;
            idx_reg       <= h_fix[IDX_BITS-1:0] & mask;
        end else if (cmd.step) begin
            if (op_reg == OP_INSERT && swap) begin
                ch_reg        <= rd_tag_reg[57:0];
                ck_reg        <= rd_key_reg;
                dist_reg      <= rd_dist + DIST_BITS'(1);
                carry_new_reg <= 1'b0;
            end else begin
                dist_reg <= dist_reg + DIST_BITS'(1);
            end
            probe_reg <= probe_reg + PROBE_BITS'(1);
            idx_reg   <= next_idx;
        end
    end

    // Result register, loaded on the final step.
    always_ff @(posedge aclk) begin
        if (cmd.step && fin) begin
            res_status   <= st;
            res_ev_valid <= (st == ST_OVERFLOW);
            res_key      <= (st == ST_NOT_FOUND) ? '0 :
                            (st == ST_PRESENT) ? rd_key_reg : req_key_reg;
            if (st == ST_OVERFLOW) begin
                res_ev_key  <= swap ? rd_key_reg : ck_reg;
                res_ev_hash <= swap ? rd_tag_reg[57:0] : ch_reg;
            end else begin
                res_ev_key  <= '0;
                res_ev_hash <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/rhht_ctrl.sv -----
// Controller of the Robin Hood hash table: clearing pass, probe sequencing, handshake.
// Depends on rhht_pkg.
`default_nettype none
module rhht_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rhht_pkg::rhht_cmd_t       cmd,
    input  wire rhht_pkg::rhht_stat_t stat
);
    import rhht_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_PROBE} state_t;
    state_t state_reg;
    logic   out_valid_reg;

    // Input is taken when idle and the result slot is free.
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.clear_wr = (state_reg == S_CLEAR);
        cmd.start    = in_valid && in_ready;
        cmd.step     = (state_reg == S_PROBE);
    end

    // State and result-valid register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: if (stat.clear_last) state_reg <= S_IDLE;
                S_IDLE:  if (cmd.start) state_reg <= S_PROBE;
                S_READ:  state_reg <= S_PROBE;
                S_PROBE: if (stat.finished) begin
                    state_reg     <= S_IDLE;
                    out_valid_reg <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_in_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_finish_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE && stat.finished) |=> out_valid_reg)
        else $error("result lost");
    a_no_start_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !out_valid_reg) else $error("start over pending result");
endmodule
`default_nettype wire

// ----- design/robin_hood_hash_table_top.sv -----
// Top level of the Robin Hood hash table: controller, datapath, config register.
// Depends on rhht_pkg, rhht_ctrl and rhht_datapath.
// m_tvalid is registered and rises at the edge that ends the final probe step;
// one slot is probed per step, 1..64 slots per item. One item at a time: the next
// item is taken the cycle after the result is taken.
// Reset: a clearing pass writes all 1024 tags empty, one per cycle, with no item
// accepted; size_log2 resets to 10.
`default_nettype none
module robin_hood_hash_table_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [3:0]   cfg_wr_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,  // key[31:0], key_hash[89:32], pad
    input  wire logic         s_tuser,  // opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,  // out_key, evicted_key, evicted_hash, pad
    output logic [2:0]        m_tuser   // status[1:0], evicted_valid[2]
);
    import rhht_pkg::*;

    rhht_cmd_t  cmd;
    rhht_stat_t stat;
    logic [3:0] size_log2_reg;
    logic [1:0] st;
    logic [31:0] rk, ek;
    logic [57:0] eh;
    logic ev;

    // Size register.
    always_ff @(posedge aclk) begin
        if (!aresetn) size_log2_reg <= 4'd10;
        else if (cfg_wr_en) size_log2_reg <= cfg_wr_data;
    end

    rhht_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd), .stat(stat)
    );

    rhht_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .size_log2(size_log2_reg),
        .in_opcode(s_tuser), .in_key(s_tdata[31:0]), .in_hash(s_tdata[89:32]),
        .res_status(st), .res_key(rk), .res_ev_valid(ev), .res_ev_key(ek),
        .res_ev_hash(eh)
    );

    assign m_tdata = {6'd0, eh, ek, rk};
    assign m_tuser = {ev, st};
endmodule
`default_nettype wire

// ----- verif/tb_robin_hood_hash_table_top.sv -----
// Self-checking testbench for the Robin Hood hash table top level.
// Depends on rhht_pkg and robin_hood_hash_table_top; holds its own table predictor.
`timescale 1ns / 100ps
`default_nettype none

module tb_robin_hood_hash_table_top;
    import rhht_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_key;
        logic        ev_valid;
        logic [31:0] ev_key;
        logic [57:0] ev_hash;
    } lookup_res_t;

    // Predicts table answers and holds the answers still due from the block.
    class hash_scoreboard;
        logic [63:0] tag_mem [TABLE_DEPTH];
        logic [31:0] key_mem [TABLE_DEPTH];
        logic [3:0]  size_log2;
        lookup_res_t due_q[$];
        int          errors;
        int          checked;
        int          n_status [4];

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                tag_mem[i] = '0;
                key_mem[i] = '0;
            end
            size_log2 = 4'd10;
            errors = 0;
            checked = 0;
        endfunction

        function lookup_res_t predict_op(logic op, logic [31:0] key, logic [57:0] hash_in);
            lookup_res_t r;
            logic [9:0]  mask;
            logic [9:0]  idx;
            logic [57:0] h;
            logic [57:0] ch;
            logic [31:0] ck;
            logic [31:0] old_key;
            logic [63:0] t;
            logic [5:0]  cur_dist;
            logic [5:0]  rd;
            bit          carrying;
            r = '0;
            mask = 10'((11'd1 << size_log2) - 11'd1);
            h = (hash_in == 0) ? 58'd64 : hash_in;
            idx = h[9:0] & mask;
            if (op == OP_FIND) begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < MAX_PROBE; i++) begin
                    t = tag_mem[idx];
                    if (t == 0) break;
                    if (t[57:0] == h) begin
                        if (key_mem[idx] == key) begin
                            r.status = ST_PRESENT;
                            r.out_key = key;
                            return r;
                        end
                    end else if (t[63:58] < i) begin
                        break;
                    end
                    idx = (idx + 10'd1) & mask;
                end
                return r;
            end
            carrying = 1;
            ch = h;
            ck = key;
            cur_dist = '0;
            for (int i = 0; i < MAX_PROBE; i++) begin
                t = tag_mem[idx];
                if (t == 0) begin
                    tag_mem[idx] = {cur_dist, ch};
                    key_mem[idx] = ck;
                    r.status = ST_INSERTED;
                    r.out_key = key;
                    return r;
                end
                rd = t[63:58];
                if (rd < cur_dist) begin
                    // Rich resident gives up its slot; carry it onward.
                    old_key = key_mem[idx];
                    tag_mem[idx] = {cur_dist, ch};
                    key_mem[idx] = ck;
                    ch = t[57:0];
                    ck = old_key;
                    cur_dist = rd;
                    carrying = 0;
                end else if (carrying && key_mem[idx] == key) begin
                    r.status = ST_PRESENT;
                    r.out_key = key;
                    return r;
                end
                idx = (idx + 10'd1) & mask;
                cur_dist = cur_dist + 6'd1;
            end
            r.status = ST_OVERFLOW;
            r.out_key = key;
            r.ev_valid = 1;
            r.ev_key = ck;
            r.ev_hash = ch;
            return r;
        endfunction

        function void note_request(logic op, logic [31:0] key, logic [57:0] h);
            due_q.push_back(predict_op(op, key, h));
        endfunction

        function void check_answer(lookup_res_t got);
            lookup_res_t want;
            if (due_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = due_q.pop_front();
            checked++;
            n_status[want.status]++;
            if (got.status !== want.status || got.out_key !== want.out_key
                    || got.ev_valid !== want.ev_valid || got.ev_key !== want.ev_key
                    || got.ev_hash !== want.ev_hash) begin
                $display("%0t: mismatch expected st=%0d key=%h ev=%0d evk=%h evh=%h",
                         $time, want.status, want.out_key, want.ev_valid,
                         want.ev_key, want.ev_hash);
                $display("%0t:          actual   st=%0d key=%h ev=%0d evk=%h evh=%h",
                         $time, got.status, got.out_key, got.ev_valid,
                         got.ev_key, got.ev_hash);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_wr_en = 0;
    logic [3:0]   cfg_wr_data = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [127:0] m_tdata;
    logic [2:0]   m_tuser;

    hash_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  idle_cycles = 0;
    int  n_sent = 0;
    logic [31:0] used_keys[$];

    localparam int WATCHDOG = 20000;

    robin_hood_hash_table_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // Result side: random stalls, check each accepted item.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_answer({m_tuser[1:0], m_tdata[31:0], m_tuser[2],
                             m_tdata[63:32], m_tdata[121:64]});
    end
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog on cycles with no accepted item; the long reset clearing pass fits.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("watchdog expired");
            $display("FAIL");
            $finish;
        end
    end

    // Valid stays high after an accept until the next item or an idle cycle replaces it.
    task automatic send_item(logic op, logic [31:0] key, logic [57:0] h);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {6'd0, h, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(op, key, h);
        n_sent++;
        @(negedge aclk);
    endtask

    // Wait for all answers, then a latency margin, then write the size register.
    task automatic set_size(logic [3:0] v);
        s_tvalid <= 0;
        while (sb.due_q.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 0;
        sb.size_log2 = v;
    endtask

    // Keys reused about half the time, hashes often clustered into a few homes to force long chains.
    task automatic random_phase(int count);
        logic [31:0] k;
        logic [57:0] h;
        logic        op;
        for (int i = 0; i < count; i++) begin
            op = $urandom_range(2) == 0;
            if (used_keys.size() > 0 && $urandom_range(99) < 50)
                k = used_keys[$urandom_range(used_keys.size() - 1)];
            else begin
                k = (($urandom_range(3) == 0) ? $urandom : $urandom_range(63));
                used_keys.push_back(k);
            end
            case ($urandom_range(3))
                0: h = 58'({$urandom, $urandom});
                1: h = 58'(k % 7) * 58'd1024 + 58'($urandom_range(3));
                2: h = 58'(k) ^ {26'h0, 32'hFFFF_FFFF};
                default: h = 58'(k & 32'h1F);
            endcase
            send_item(op, k, h);
        end
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1;
        // Directed: extremes, zero hash, misses, duplicates, overflow by one home.
        send_item(OP_FIND, 32'd5, 58'd5);
        send_item(OP_INSERT, 32'd0, 58'd0);
        send_item(OP_FIND, 32'd0, 58'd0);
        send_item(OP_FIND, 32'd0, 58'd64);
        send_item(OP_INSERT, 32'hFFFF_FFFF, {58{1'b1}});
        send_item(OP_INSERT, 32'hFFFF_FFFF, 58'd7);
        send_item(OP_FIND, 32'hFFFF_FFFF, {58{1'b1}});
        send_item(OP_FIND, 32'hFFFF_FFFE, {58{1'b1}});
        set_size(4'd4);
        for (int i = 0; i < 18; i++)
            send_item(OP_INSERT, 32'h100 + i, 58'h3 + (58'(i) << 4));
        send_item(OP_FIND, 32'h105, 58'h3 + (58'd5 << 4));
        send_item(OP_FIND, 32'h999, 58'h3);
        set_size(4'd0);
        send_item(OP_INSERT, 32'h55, 58'h1);
        send_item(OP_FIND, 32'h55, 58'h1);

        // Random phases over several sizes and idle patterns.
        send_idle_pct = 19; recv_idle_pct = 57;
        set_size(4'd5);
        random_phase(300);
        set_size(4'd15);
        random_phase(150);
        send_idle_pct = 57; recv_idle_pct = 19;
        set_size(4'd4);
        random_phase(250);
        set_size(4'd10);
        random_phase(200);
        send_idle_pct = 0; recv_idle_pct = 0;
        set_size(4'd7);
        random_phase(250);
        set_size(4'd6);
        random_phase(150);

        s_tvalid <= 0;
        while (sb.due_q.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        $display("Sent %0d items, checked %0d results over sizes 0..15.", n_sent, sb.checked);
        $display("Status counts: new %0d, present %0d, miss %0d, overflow %0d.",
                 sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3]);
        if (sb.errors == 0 && sb.due_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

`default_nettype wire

// ----- filelist.f -----
design/rhht_pkg.sv
design/rhht_datapath.sv
design/rhht_ctrl.sv
design/robin_hood_hash_table_top.sv
verif/tb_robin_hood_hash_table_top.sv
